FILE: hdl/pidsl_pkg.sv
package pidsl_pkg;

   // Q16.16 unity and the two static-friction gains
   localparam logic signed [31:0] Q_ONE           = 32'sd65536;
   localparam logic signed [31:0] Q_MINUS_ONE     = -32'sd65536;
   localparam logic [16:0]        Q_ONE_MAG       = 17'h10000;
   localparam logic [8:0]         FRIC_GAIN_SAME  = 9'd400;
   localparam logic [8:0]         FRIC_GAIN_CROSS = 9'd100;

   // configuration register indexes
   localparam logic [2:0] REG_SETPOINT       = 3'd0;
   localparam logic [2:0] REG_GAIN_P         = 3'd1;
   localparam logic [2:0] REG_GAIN_I         = 3'd2;
   localparam logic [2:0] REG_GAIN_D         = 3'd3;
   localparam logic [2:0] REG_MAX_OUTPUT     = 3'd4;
   localparam logic [2:0] REG_INTEG_BOUND    = 3'd5;

   // terms handed from the error stage to the multiply stage
   typedef struct packed {
      logic signed [31:0] err;
      logic signed [32:0] diff;
      logic signed [31:0] integ;
      logic signed [26:0] fric;
      logic               sp_zero;
   } pidsl_term_type;

endpackage

FILE: hdl/pidsl_error_stage.sv
module pidsl_error_stage
   import pidsl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                item_valid,
   input  logic signed [31:0]  measure,
   input  logic signed [31:0]  setpoint,
   input  logic [30:0]         integ_bound,
   output pidsl_term_type      term,
   output logic                term_valid
);

   logic signed [31:0] prev_error_ff, prev_error_in;
   logic signed [31:0] accum_error_ff, accum_error_in;
   pidsl_term_type     term_ff, term_in;
   logic               valid_ff;

   logic signed [32:0] err_raw;
   logic signed [31:0] err_sat;
   logic signed [32:0] integ_raw;
   logic signed [32:0] lim_pos;
   logic signed [32:0] lim_neg;
   logic signed [31:0] integ_clamped;
   logic               sp_big;
   logic               meas_small;
   logic               crossing;
   logic signed [31:0] meas_neg;
   logic [16:0]        abs_meas;
   logic [16:0]        fric_rem;
   logic [25:0]        fric_mag;
   logic signed [26:0] fric;

   always_comb begin
      // saturate the error to 32 bits
      err_raw = {setpoint[31], setpoint} - {measure[31], measure};
      if (err_raw[32] != err_raw[31]) begin
         err_sat = err_raw[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         err_sat = err_raw[31:0];
      end

      // integral with symmetric clamp
      integ_raw = {accum_error_ff[31], accum_error_ff} + {err_sat[31], err_sat};
      lim_pos   = $signed({2'b00, integ_bound});
      lim_neg   = -lim_pos;
      if (integ_raw > lim_pos) begin
         integ_clamped = lim_pos[31:0];
      end else if (integ_raw < lim_neg) begin
         integ_clamped = lim_neg[31:0];
      end else begin
         integ_clamped = integ_raw[31:0];
      end

      // static friction near standstill
      sp_big     = (setpoint >= Q_ONE) || (setpoint <= Q_MINUS_ONE);
      meas_small = (measure > Q_MINUS_ONE) && (measure < Q_ONE);
      crossing   = (!setpoint[31] && (setpoint != 32'sd0) && measure[31]) ||
                   (setpoint[31] && !measure[31] && (measure != 32'sd0));
      meas_neg   = -measure;
      abs_meas   = measure[31] ? meas_neg[16:0] : measure[16:0];
      fric_rem   = Q_ONE_MAG - abs_meas;
      fric_mag   = 26'(fric_rem) * 26'(crossing ? FRIC_GAIN_CROSS : FRIC_GAIN_SAME);
      if (sp_big && meas_small) begin
         fric = setpoint[31] ? -$signed({1'b0, fric_mag}) : $signed({1'b0, fric_mag});
      end else begin
         fric = 27'sd0;
      end

      term_in.err     = err_sat;
      term_in.diff    = {err_sat[31], err_sat} - {prev_error_ff[31], prev_error_ff};
      term_in.integ   = integ_clamped;
      term_in.fric    = fric;
      term_in.sp_zero = (setpoint == 32'sd0);

      // advance the loop state only when a real item enters
      prev_error_in  = prev_error_ff;
      accum_error_in = accum_error_ff;
      if (load && item_valid) begin
         prev_error_in  = err_sat;
         accum_error_in = term_in.sp_zero ? 32'sd0 : integ_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff  <= '0;
         accum_error_ff <= '0;
         valid_ff       <= 1'b0;
      end else begin
         prev_error_ff  <= prev_error_in;
         accum_error_ff <= accum_error_in;
         if (load) begin
            valid_ff <= item_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         term_ff <= term_in;
      end
   end

   assign term       = term_ff;
   assign term_valid = valid_ff;

endmodule

FILE: hdl/pid_speed_loop_friction_comp.sv
// Speed-loop PID controller with integral clamp and static-friction feed-forward,
// all in signed Q16.16. Each measure transfer yields one drive transfer, in order.
// The pipeline has four register levels: input register, error stage (error,
// derivative, clamped integral and friction term, where the loop state lives),
// multiply stage (three gain products) and the output register (floor, sum and
// clamp to max_output). One item is taken every cycle while rsp_ready stays high;
// each stage holds only while the one after it is full and stalled, so bubbles
// close up and a request can still be taken while a result waits. The loop
// state (previous error and integral) is updated in the error stage as each item
// enters it, which is what lets items follow back to back. Configuration writes
// take effect at the clock edge and should be made only while no item is in
// flight; indexes above five are ignored. A zero setpoint forces drive to zero
// and clears the integral.
module pid_speed_loop_friction_comp
   import pidsl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration write port
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   // measured speed
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_measure,
   // drive result
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_drive,
   output logic                rsp_saturated
);

   // configuration registers
   logic signed [31:0] setpoint_ff;
   logic signed [31:0] gain_p_ff;
   logic signed [31:0] gain_i_ff;
   logic signed [31:0] gain_d_ff;
   logic [30:0]        max_output_ff;
   logic [30:0]        integ_bound_ff;

   // pipeline stage enables
   logic en_out, en_mul, en_err, en_in;

   // input register
   logic               in_valid_ff;
   logic signed [31:0] measure_ff;

   // error stage
   pidsl_term_type     term;
   logic               term_valid;

   // multiply stage
   logic               mul_valid_ff;
   logic signed [63:0] prod_p_ff, prod_p_in;
   logic signed [63:0] prod_i_ff, prod_i_in;
   logic signed [64:0] prod_d_ff, prod_d_in;
   logic signed [26:0] fric_ff;
   logic               sp_zero_ff;

   // output stage
   logic signed [47:0] term_p;
   logic signed [47:0] term_i;
   logic signed [48:0] term_d;
   logic signed [50:0] sum;
   logic signed [50:0] lim_pos;
   logic signed [50:0] lim_neg;
   logic signed [31:0] drive_in, drive_ff;
   logic               sat_in, sat_ff;
   logic               out_valid_ff;

   // configuration writes; unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff    <= '0;
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
         max_output_ff  <= '0;
         integ_bound_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_SETPOINT:    setpoint_ff    <= csr_wdata;
            REG_GAIN_P:      gain_p_ff      <= csr_wdata;
            REG_GAIN_I:      gain_i_ff      <= csr_wdata;
            REG_GAIN_D:      gain_d_ff      <= csr_wdata;
            REG_MAX_OUTPUT:  max_output_ff  <= csr_wdata[30:0];
            REG_INTEG_BOUND: integ_bound_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // a stage may load when it is empty or the next stage loads too
   assign en_out    = !out_valid_ff || rsp_ready;
   assign en_mul    = !mul_valid_ff || en_out;
   assign en_err    = !term_valid || en_mul;
   assign en_in     = !in_valid_ff || en_err;
   assign req_ready = en_in;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en_in) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_in) begin
         measure_ff <= req_measure;
      end
   end

   // error, derivative, integral and friction; owns the loop state
   pidsl_error_stage u_error_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (en_err),
      .item_valid  (in_valid_ff),
      .measure     (measure_ff),
      .setpoint    (setpoint_ff),
      .integ_bound (integ_bound_ff),
      .term        (term),
      .term_valid  (term_valid)
   );

   // exact gain products, Q32.32
   always_comb begin
      prod_p_in = $signed(gain_p_ff) * $signed(term.err);
      prod_i_in = $signed(gain_i_ff) * $signed(term.integ);
      prod_d_in = $signed(gain_d_ff) * $signed(term.diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en_mul) begin
         mul_valid_ff <= term_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_mul) begin
         prod_p_ff  <= prod_p_in;
         prod_i_ff  <= prod_i_in;
         prod_d_ff  <= prod_d_in;
         fric_ff    <= term.fric;
         sp_zero_ff <= term.sp_zero;
      end
   end

   // drop the low 16 bits (floor), add up exactly, then clamp to max_output; a zero setpoint forces zero
   always_comb begin
      term_p  = $signed(prod_p_ff[63:16]);
      term_i  = $signed(prod_i_ff[63:16]);
      term_d  = $signed(prod_d_ff[64:16]);
      sum     = term_p + term_i + term_d + fric_ff;
      lim_pos = $signed({20'd0, max_output_ff});
      lim_neg = -lim_pos;
      if (sp_zero_ff) begin
         drive_in = 32'sd0;
         sat_in   = 1'b0;
      end else if (sum > lim_pos) begin
         drive_in = $signed({1'b0, max_output_ff});
         sat_in   = 1'b1;
      end else if (sum < lim_neg) begin
         drive_in = -$signed({1'b0, max_output_ff});
         sat_in   = 1'b1;
      end else begin
         drive_in = sum[31:0];
         sat_in   = 1'b0;
      end
   end

   // output register: hold while the result is not taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en_out) begin
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         drive_ff <= drive_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_drive     = drive_ff;
   assign rsp_saturated = sat_ff;

endmodule
